FILE: hw/rtl/dpid_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// dpid_pkg
// Shared types, widths and helper functions for the dual PID drive controller.
// ============================================================================
package dpid_pkg;

  // Field and register widths.
  localparam int POS_W          = 24;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int REG_W          = 24;
  localparam int ERR_W          = 26;
  localparam int INT_W          = 32;
  localparam int PWR_W          = 8;
  localparam int NUM_REGS       = 8;
  localparam int CFG_IW         = $clog2(NUM_REGS);
  localparam int CFG_AW         = CFG_IW + 2;
  localparam int APB_DW         = 32;

  // Internal arithmetic widths.
  localparam int WIDE_W = (((POS_W + 1) > REG_W) ? (POS_W + 1) : REG_W) + 1;
  localparam int EXT_W  = ((WIDE_W > ERR_W) ? WIDE_W : ERR_W) + 1;
  localparam int DER_W  = ERR_W + 1;
  localparam int PROD_W = INT_W + REG_W;
  localparam int LOOP_W = PROD_W + 2;
  localparam int MIX_W  = LOOP_W + 1;

  // Output scaling: divide by DIV_K * 2^GAIN_FRAC_BITS, saturate to PWR_MAX.
  localparam int PWR_MAX  = 100;
  localparam int DIV_K    = 12;
  localparam int Q_W      = $clog2((PWR_MAX + 1) * DIV_K);
  localparam int MAG_W    = $clog2(PWR_MAX + 1);
  localparam int RECIP_SH = 16;
  localparam int RECIP    = (1 << RECIP_SH) / DIV_K + 1;
  localparam logic [MIX_W-1:0] SAT_LIM =
    MIX_W'((PWR_MAX + 1) * DIV_K) << GAIN_FRAC_BITS;

  typedef enum logic [CFG_IW-1:0] {
    REG_LAT_P    = 3'd0,
    REG_LAT_I    = 3'd1,
    REG_LAT_D    = 3'd2,
    REG_TURN_P   = 3'd3,
    REG_TURN_I   = 3'd4,
    REG_TURN_D   = 3'd5,
    REG_LAT_TGT  = 3'd6,
    REG_TURN_TGT = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [REG_W-1:0] p;
    logic signed [REG_W-1:0] i;
    logic signed [REG_W-1:0] d;
  } gains_t;

  // Load enables for the three loop stages, and the state update strobe.
  typedef struct packed {
    logic       upd;
    logic [2:0] en;
  } loop_ctrl_t;

  localparam logic signed [EXT_W-1:0] ERR_HI =
    {{(EXT_W - ERR_W + 1){1'b0}}, {(ERR_W - 1){1'b1}}};
  localparam logic signed [EXT_W-1:0] ERR_LO =
    {{(EXT_W - ERR_W + 1){1'b1}}, {(ERR_W - 1){1'b0}}};

  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [EXT_W-1:0] v);
    logic signed [ERR_W-1:0] r;
    if (v > ERR_HI) begin
      r = ERR_HI[ERR_W-1:0];
    end else if (v < ERR_LO) begin
      r = ERR_LO[ERR_W-1:0];
    end else begin
      r = v[ERR_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [INT_W-1:0] sat_int(input logic signed [INT_W:0] v);
    logic signed [INT_W-1:0] r;
    if (v[INT_W] != v[INT_W-1]) begin
      r = v[INT_W] ? {1'b1, {(INT_W - 1){1'b0}}} : {1'b0, {(INT_W - 1){1'b1}}};
    end else begin
      r = v[INT_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/dual_pid_tank_drive_controller.sv
`timescale 1ns / 1ps
// ============================================================================
// dual_pid_tank_drive_controller
// Two PID loops (lateral and turn) driving left and right tank-drive power.
// ============================================================================
// Each input word is one control tick: four wheel encoder positions and a
// zero flag. The block answers every tick with one output word carrying the
// right and left drive power in percent, the lateral and turn errors and the
// encoder-clear strobe. It is an eight-stage pipeline that accepts one word
// per clock while the output is not stalled. The loop state (previous errors
// and the saturating integrals) is updated in a single pipeline stage, so
// every tick sees the state left by the tick just before it. Each stage holds
// its own valid bit and only stalls when the stage after it is full and
// stalled itself, so new ticks keep flowing in while a finished result waits
// at the output.
// Gains and targets are written through the APB port; the user must write
// them only while the block is idle, as the block does not enforce it. Reads
// return the register sign-extended to 32 bits.
module dual_pid_tank_drive_controller (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dpid_pkg::CFG_AW-1:0]        paddr,
  input  logic [dpid_pkg::APB_DW-1:0]        pwdata,
  output logic [dpid_pkg::APB_DW-1:0]        prdata,
  output logic                               pready,
  // Tick input.
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [dpid_pkg::POS_W-1:0]  right_front_pos_i,
  input  logic signed [dpid_pkg::POS_W-1:0]  left_front_pos_i,
  input  logic signed [dpid_pkg::POS_W-1:0]  left_back_pos_i,
  input  logic signed [dpid_pkg::POS_W-1:0]  right_back_pos_i,
  input  logic                               zero_positions_i,
  // Result output.
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [dpid_pkg::PWR_W-1:0]  right_power_o,
  output logic signed [dpid_pkg::PWR_W-1:0]  left_power_o,
  output logic signed [dpid_pkg::ERR_W-1:0]  lateral_error_o,
  output logic signed [dpid_pkg::ERR_W-1:0]  turn_error_o,
  output logic                               clear_encoders_o
);
  import dpid_pkg::*;

  // Pipeline stages.
  localparam int ST_IN   = 0;
  localparam int ST_AVG  = 1;
  localparam int ST_ERR  = 2;
  localparam int ST_SUM  = 4;
  localparam int ST_MIX  = 5;
  localparam int ST_SAT  = 6;
  localparam int ST_OUT  = 7;
  localparam int NST     = 8;
  localparam int PROD2_W = Q_W + RECIP_SH;

  logic [NST-1:0] v_q;
  logic [NST-1:0] rdy;
  logic [NST-1:0] zero_q;

  // Configuration.
  gains_t                  lat_gains, turn_gains;
  logic signed [REG_W-1:0] lat_tgt, turn_tgt;

  dpid_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .lat_gains_o  (lat_gains),
    .turn_gains_o (turn_gains),
    .lat_tgt_o    (lat_tgt),
    .turn_tgt_o   (turn_tgt)
  );

  // A stage can take a new word when it is empty or its word moves on.
  always_comb begin
    rdy[NST-1] = !v_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[ST_IN]) begin
        v_q[ST_IN] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // The zero flag travels with its word down to the output.
  always_ff @(posedge clk_i) begin
    if (rdy[ST_IN]) begin
      zero_q[ST_IN] <= zero_positions_i;
    end
    for (int k = 1; k < NST; k++) begin
      if (rdy[k]) begin
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  assign in_ready_o  = rdy[ST_IN];
  assign out_valid_o = v_q[ST_OUT];

  // Input register.
  logic signed [POS_W-1:0] rf_q, lf_q, lb_q, rb_q;

  always_ff @(posedge clk_i) begin
    if (rdy[ST_IN]) begin
      rf_q <= right_front_pos_i;
      lf_q <= left_front_pos_i;
      lb_q <= left_back_pos_i;
      rb_q <= right_back_pos_i;
    end
  end

  // Average of the four wheels, truncated toward zero, and the front
  // difference. A zeroed tick sees all positions as zero.
  logic signed [POS_W+1:0] sum4, sum4_adj;
  logic signed [POS_W:0]   fdiff;
  logic signed [POS_W-1:0] avg_q;
  logic signed [POS_W:0]   fdiff_q;

  always_comb begin
    if (zero_q[ST_IN]) begin
      sum4  = '0;
      fdiff = '0;
    end else begin
      sum4  = (POS_W + 2)'(rf_q) + (POS_W + 2)'(lf_q)
            + (POS_W + 2)'(lb_q) + (POS_W + 2)'(rb_q);
      fdiff = (POS_W + 1)'(rf_q) - (POS_W + 1)'(lf_q);
    end
    sum4_adj = sum4[POS_W+1] ? sum4 + (POS_W + 2)'(3) : sum4;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_AVG]) begin
      avg_q   <= sum4_adj[POS_W+1:2];
      fdiff_q <= fdiff;
    end
  end

  // The two loops span the error, product and sum stages.
  loop_ctrl_t              loop_ctrl;
  logic signed [ERR_W-1:0] lat_err, turn_err;
  logic signed [LOOP_W-1:0] lat_sum, turn_sum;

  assign loop_ctrl.en  = rdy[ST_SUM:ST_ERR];
  assign loop_ctrl.upd = rdy[ST_ERR] && v_q[ST_AVG];

  dpid_loop u_lat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (loop_ctrl),
    .meas_i  (WIDE_W'(avg_q)),
    .tgt_i   (lat_tgt),
    .gains_i (lat_gains),
    .err_o   (lat_err),
    .sum_o   (lat_sum)
  );

  dpid_loop u_turn (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (loop_ctrl),
    .meas_i  (WIDE_W'(fdiff_q)),
    .tgt_i   (turn_tgt),
    .gains_i (turn_gains),
    .err_o   (turn_err),
    .sum_o   (turn_sum)
  );

  // Side mix: index 0 is right (lateral plus turn), 1 is left.
  logic signed [MIX_W-1:0] mix_q [2];
  logic signed [ERR_W-1:0] lat_err_m_q, turn_err_m_q;

  always_ff @(posedge clk_i) begin
    if (rdy[ST_MIX]) begin
      mix_q[0]     <= MIX_W'(lat_sum) + MIX_W'(turn_sum);
      mix_q[1]     <= MIX_W'(lat_sum) - MIX_W'(turn_sum);
      lat_err_m_q  <= lat_err;
      turn_err_m_q <= turn_err;
    end
  end

  // Magnitude, saturation check and the whole multiples of 2^frac. Below the
  // saturation limit the magnitude fits in Q_W bits above the fraction.
  logic [MIX_W-1:0]        mag_abs [2];
  logic                    neg_q [2];
  logic                    sat_q [2];
  logic [Q_W-1:0]          q_q [2];
  logic signed [ERR_W-1:0] lat_err_s_q, turn_err_s_q;

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      mag_abs[s] = mix_q[s][MIX_W-1] ? -mix_q[s] : mix_q[s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_SAT]) begin
      for (int s = 0; s < 2; s++) begin
        neg_q[s] <= mix_q[s][MIX_W-1];
        sat_q[s] <= (mag_abs[s] >= SAT_LIM);
        q_q[s]   <= mag_abs[s][GAIN_FRAC_BITS +: Q_W];
      end
      lat_err_s_q  <= lat_err_m_q;
      turn_err_s_q <= turn_err_m_q;
    end
  end

  // Divide by the loop constant with a reciprocal multiply; exact for every
  // value below the saturation limit. Then restore the sign.
  logic [PROD2_W-1:0]      rprod [2];
  logic [MAG_W-1:0]        mag [2];
  logic signed [PWR_W-1:0] pwr [2];
  logic signed [PWR_W-1:0] pwr_q [2];
  logic signed [ERR_W-1:0] lat_err_o_q, turn_err_o_q;

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      rprod[s] = PROD2_W'(q_q[s]) * PROD2_W'(RECIP);
      mag[s]   = sat_q[s] ? MAG_W'(PWR_MAX) : rprod[s][RECIP_SH +: MAG_W];
      pwr[s]   = neg_q[s] ? -PWR_W'(mag[s]) : PWR_W'(mag[s]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_OUT]) begin
      pwr_q[0]     <= pwr[0];
      pwr_q[1]     <= pwr[1];
      lat_err_o_q  <= lat_err_s_q;
      turn_err_o_q <= turn_err_s_q;
    end
  end

  assign right_power_o    = pwr_q[0];
  assign left_power_o     = pwr_q[1];
  assign lateral_error_o  = lat_err_o_q;
  assign turn_error_o     = turn_err_o_q;
  assign clear_encoders_o = zero_q[ST_OUT];

endmodule

FILE: hw/rtl/dpid_cfg.sv
`timescale 1ns / 1ps
// ============================================================================
// dpid_cfg
// APB register file holding the six loop gains and the two targets.
// ============================================================================
module dpid_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dpid_pkg::CFG_AW-1:0]       paddr,
  input  logic [dpid_pkg::APB_DW-1:0]       pwdata,
  output logic [dpid_pkg::APB_DW-1:0]       prdata,
  output logic                              pready,
  output dpid_pkg::gains_t                  lat_gains_o,
  output dpid_pkg::gains_t                  turn_gains_o,
  output logic signed [dpid_pkg::REG_W-1:0] lat_tgt_o,
  output logic signed [dpid_pkg::REG_W-1:0] turn_tgt_o
);
  import dpid_pkg::*;

  logic [REG_W-1:0] regs_q [NUM_REGS];
  cfg_reg_e         idx;

  assign idx    = cfg_reg_e'(paddr[CFG_AW-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_REGS; k++) begin
        regs_q[k] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      regs_q[idx] <= pwdata[REG_W-1:0];
    end
  end

  // Reads return the register sign-extended to the bus width.
  assign prdata = {{(APB_DW - REG_W){regs_q[idx][REG_W-1]}}, regs_q[idx]};

  assign lat_gains_o.p  = regs_q[REG_LAT_P];
  assign lat_gains_o.i  = regs_q[REG_LAT_I];
  assign lat_gains_o.d  = regs_q[REG_LAT_D];
  assign turn_gains_o.p = regs_q[REG_TURN_P];
  assign turn_gains_o.i = regs_q[REG_TURN_I];
  assign turn_gains_o.d = regs_q[REG_TURN_D];
  assign lat_tgt_o      = regs_q[REG_LAT_TGT];
  assign turn_tgt_o     = regs_q[REG_TURN_TGT];

endmodule

FILE: hw/rtl/dpid_loop.sv
`timescale 1ns / 1ps
// ============================================================================
// dpid_loop
// One PID loop: error and integral update, gain products, and their sum.
// ============================================================================
module dpid_loop (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dpid_pkg::loop_ctrl_t               ctrl_i,
  input  logic signed [dpid_pkg::WIDE_W-1:0] meas_i,
  input  logic signed [dpid_pkg::REG_W-1:0]  tgt_i,
  input  dpid_pkg::gains_t                   gains_i,
  output logic signed [dpid_pkg::ERR_W-1:0]  err_o,
  output logic signed [dpid_pkg::LOOP_W-1:0] sum_o
);
  import dpid_pkg::*;

  logic signed [ERR_W-1:0]       last_err_q;
  logic signed [INT_W-1:0]       integ_q;
  logic signed [EXT_W-1:0]       diff;
  logic signed [ERR_W-1:0]       err_d;
  logic signed [DER_W-1:0]       der_d;
  logic signed [INT_W-1:0]       int_d;

  logic signed [ERR_W-1:0]       err_a_q, err_b_q, err_c_q;
  logic signed [DER_W-1:0]       der_a_q;
  logic signed [INT_W-1:0]       int_a_q;
  logic signed [ERR_W+REG_W-1:0] pe_q;
  logic signed [DER_W+REG_W-1:0] pd_q;
  logic signed [PROD_W-1:0]      pi_q;
  logic signed [LOOP_W-1:0]      sum_q;

  always_comb begin
    diff  = EXT_W'(meas_i) - EXT_W'(tgt_i);
    err_d = sat_err(diff);
    der_d = DER_W'(err_d) - DER_W'(last_err_q);
    int_d = sat_int((INT_W + 1)'(integ_q) + (INT_W + 1)'(err_d));
  end

  // Loop state advances once per word, as it enters the error stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      integ_q    <= '0;
    end else if (ctrl_i.upd) begin
      last_err_q <= err_d;
      integ_q    <= int_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      err_a_q <= err_d;
      der_a_q <= der_d;
      int_a_q <= int_d;
    end
    if (ctrl_i.en[1]) begin
      err_b_q <= err_a_q;
      pe_q    <= err_a_q * $signed(gains_i.p);
      pd_q    <= der_a_q * $signed(gains_i.d);
      pi_q    <= int_a_q * $signed(gains_i.i);
    end
    if (ctrl_i.en[2]) begin
      err_c_q <= err_b_q;
      sum_q   <= LOOP_W'(pe_q) + LOOP_W'(pd_q) + LOOP_W'(pi_q);
    end
  end

  assign err_o = err_c_q;
  assign sum_o = sum_q;

endmodule

FILE: hw/rtl/dpid_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// dpid_checker
// Port-level checks for the dual PID drive controller, bound to the top level.
// ============================================================================
module dpid_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [dpid_pkg::PWR_W-1:0]  right_power_o,
  input logic signed [dpid_pkg::PWR_W-1:0]  left_power_o,
  input logic signed [dpid_pkg::ERR_W-1:0]  lateral_error_o,
  input logic signed [dpid_pkg::ERR_W-1:0]  turn_error_o,
  input logic                               clear_encoders_o
);
  import dpid_pkg::*;

  // Delivered power always lies within the saturation limits.
  a_right_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (right_power_o <= PWR_W'(PWR_MAX)) &&
                    (right_power_o >= -PWR_W'(PWR_MAX)))
    else $error("right power out of range");

  a_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (left_power_o <= PWR_W'(PWR_MAX)) &&
                    (left_power_o >= -PWR_W'(PWR_MAX)))
    else $error("left power out of range");

  // With the output stage empty nothing downstream can hold the input back.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // A stalled result holds its word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(right_power_o) &&
      $stable(left_power_o) && $stable(lateral_error_o) && $stable(turn_error_o) &&
      $stable(clear_encoders_o))
    else $error("stalled result changed");

endmodule

bind dual_pid_tank_drive_controller dpid_checker u_dpid_checker (.*);

FILE: test/dpid_drive_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// dpid_drive_checker
// Tracks the gain registers, predicts each control tick and checks the results.
// ============================================================================
module dpid_drive_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel_i,
  input  logic                               penable_i,
  input  logic                               pwrite_i,
  input  logic                               pready_i,
  input  logic [dpid_pkg::CFG_AW-1:0]        paddr_i,
  input  logic [dpid_pkg::APB_DW-1:0]        pwdata_i,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic signed [dpid_pkg::POS_W-1:0]  right_front_pos_i,
  input  logic signed [dpid_pkg::POS_W-1:0]  left_front_pos_i,
  input  logic signed [dpid_pkg::POS_W-1:0]  left_back_pos_i,
  input  logic signed [dpid_pkg::POS_W-1:0]  right_back_pos_i,
  input  logic                               zero_positions_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic signed [dpid_pkg::PWR_W-1:0]  right_power_i,
  input  logic signed [dpid_pkg::PWR_W-1:0]  left_power_i,
  input  logic signed [dpid_pkg::ERR_W-1:0]  lateral_error_i,
  input  logic signed [dpid_pkg::ERR_W-1:0]  turn_error_i,
  input  logic                               clear_encoders_i,
  output int                                 mismatch_count_o,
  output int                                 outstanding_o
);
  import dpid_pkg::*;

  typedef struct packed {
    logic signed [PWR_W-1:0] right_power;
    logic signed [PWR_W-1:0] left_power;
    logic signed [ERR_W-1:0] lateral_error;
    logic signed [ERR_W-1:0] turn_error;
    logic                    clear_encoders;
  } drive_word_t;

  localparam int     WHEELS     = 4;
  localparam int     REPORT_CAP = 40;
  localparam longint ERR_LIM    = longint'(1) <<< (ERR_W - 1);
  localparam longint INT_LIM    = longint'(1) <<< (INT_W - 1);
  localparam longint PWR_DIV    = longint'(DIV_K) <<< GAIN_FRAC_BITS;

  logic signed [REG_W-1:0] gain_reg [NUM_REGS];
  longint                  prev_lat_err;
  longint                  lat_integral;
  longint                  prev_turn_err;
  longint                  turn_integral;
  drive_word_t             expected_drive_q [$];
  int                      mismatches;

  function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [PWR_W-1:0] power_pct(input longint scaled);
    return PWR_W'(clamp_to(scaled / PWR_DIV, -PWR_MAX, PWR_MAX));
  endfunction

  // Runs one control tick against the local copy of the loop state.
  function automatic drive_word_t predict_tick(input logic signed [POS_W-1:0] rf,
                                               input logic signed [POS_W-1:0] lf,
                                               input logic signed [POS_W-1:0] lb,
                                               input logic signed [POS_W-1:0] rb,
                                               input logic zp);
    longint      rfw, lfw, lbw, rbw;
    longint      lat_err, turn_err, lat_der, turn_der, lat_sum, turn_sum;
    drive_word_t w;
    rfw = rf;
    lfw = lf;
    lbw = lb;
    rbw = rb;
    if (zp) begin
      rfw = 0;
      lfw = 0;
      lbw = 0;
      rbw = 0;
    end
    lat_err  = clamp_to((rfw + lfw + lbw + rbw) / WHEELS - gain_reg[REG_LAT_TGT],
                        -ERR_LIM, ERR_LIM - 1);
    turn_err = clamp_to((rfw - lfw) - gain_reg[REG_TURN_TGT], -ERR_LIM, ERR_LIM - 1);
    lat_der  = lat_err - prev_lat_err;
    turn_der = turn_err - prev_turn_err;
    lat_integral  = clamp_to(lat_integral + lat_err, -INT_LIM, INT_LIM - 1);
    turn_integral = clamp_to(turn_integral + turn_err, -INT_LIM, INT_LIM - 1);
    lat_sum  = lat_err * gain_reg[REG_LAT_P] + lat_der * gain_reg[REG_LAT_D]
             + lat_integral * gain_reg[REG_LAT_I];
    turn_sum = turn_err * gain_reg[REG_TURN_P] + turn_der * gain_reg[REG_TURN_D]
             + turn_integral * gain_reg[REG_TURN_I];
    w.right_power    = power_pct(lat_sum + turn_sum);
    w.left_power     = power_pct(lat_sum - turn_sum);
    w.lateral_error  = ERR_W'(lat_err);
    w.turn_error     = ERR_W'(turn_err);
    w.clear_encoders = zp;
    prev_lat_err  = lat_err;
    prev_turn_err = turn_err;
    return w;
  endfunction

  task automatic flag_error(input string msg);
    if (mismatches < REPORT_CAP) begin
      $display("[%0t] drive check: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    drive_word_t want;
    if (!rst_ni) begin
      foreach (gain_reg[r]) gain_reg[r] = '0;
      prev_lat_err  = 0;
      lat_integral  = 0;
      prev_turn_err = 0;
      turn_integral = 0;
      expected_drive_q.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[CFG_AW-1:2] < NUM_REGS) begin
          gain_reg[paddr_i[CFG_AW-1:2]] = pwdata_i[REG_W-1:0];
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_drive_q.push_back(predict_tick(right_front_pos_i, left_front_pos_i,
                                                left_back_pos_i, right_back_pos_i,
                                                zero_positions_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_drive_q.size() == 0) begin
          flag_error("result word arrived with no tick outstanding");
        end else begin
          want = expected_drive_q.pop_front();
          if (right_power_i !== want.right_power) begin
            flag_error($sformatf("right_power got %0d want %0d",
                                 right_power_i, want.right_power));
          end
          if (left_power_i !== want.left_power) begin
            flag_error($sformatf("left_power got %0d want %0d",
                                 left_power_i, want.left_power));
          end
          if (lateral_error_i !== want.lateral_error) begin
            flag_error($sformatf("lateral_error got %0d want %0d",
                                 lateral_error_i, want.lateral_error));
          end
          if (turn_error_i !== want.turn_error) begin
            flag_error($sformatf("turn_error got %0d want %0d",
                                 turn_error_i, want.turn_error));
          end
          if (clear_encoders_i !== want.clear_encoders) begin
            flag_error($sformatf("clear_encoders got %b want %b",
                                 clear_encoders_i, want.clear_encoders));
          end
        end
      end
      mismatch_count_o <= mismatches;
      outstanding_o    <= expected_drive_q.size();
    end
  end

endmodule

FILE: test/dual_pid_tank_drive_controller_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// dual_pid_tank_drive_controller_tb
// Stimulus and verdict for the dual PID tank-drive controller.
// ============================================================================
// The bench writes all eight gain and target registers over APB, then streams
// control ticks through the valid/ready input while the output side stalls at
// random. A checker beside the block predicts every result word and counts
// mismatches; this module only generates traffic and reports the outcome.
module dual_pid_tank_drive_controller_tb;
  import dpid_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 2;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 5;
  localparam int PUSH_LO        = 1 << (POS_W - 2);
  localparam int POS_MAX_I      = (1 << (POS_W - 1)) - 1;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W - 1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W - 1){1'b0}}};
  localparam logic signed [REG_W-1:0] REG_MAX = {1'b0, {(REG_W - 1){1'b1}}};
  localparam logic signed [REG_W-1:0] REG_MIN = {1'b1, {(REG_W - 1){1'b0}}};

  // Kinds of tick runs in the random part.
  typedef enum int {
    MIX_NEAR_TARGET,
    MIX_FULL_RANGE,
    MIX_PUSH_HIGH,
    MIX_PUSH_LOW,
    MIX_CORNER
  } tick_mix_e;

  // Register settings used by the random phases.
  typedef enum int {
    PLAN_MODERATE,
    PLAN_ALL_MAX,
    PLAN_ALL_MIN,
    PLAN_CROSSED
  } gain_plan_e;

  logic                     clk_i             = 1'b0;
  logic                     rst_ni            = 1'b0;
  logic                     psel              = 1'b0;
  logic                     penable           = 1'b0;
  logic                     pwrite            = 1'b0;
  logic [CFG_AW-1:0]        paddr             = '0;
  logic [APB_DW-1:0]        pwdata            = '0;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;
  logic                     in_valid_i        = 1'b0;
  logic                     in_ready_o;
  logic signed [POS_W-1:0]  right_front_pos_i = '0;
  logic signed [POS_W-1:0]  left_front_pos_i  = '0;
  logic signed [POS_W-1:0]  left_back_pos_i   = '0;
  logic signed [POS_W-1:0]  right_back_pos_i  = '0;
  logic                     zero_positions_i  = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i       = 1'b0;
  logic signed [PWR_W-1:0]  right_power_o;
  logic signed [PWR_W-1:0]  left_power_o;
  logic signed [ERR_W-1:0]  lateral_error_o;
  logic signed [ERR_W-1:0]  turn_error_o;
  logic                     clear_encoders_o;

  int mismatch_count;
  int outstanding;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int quiet_cycles = 0;

  // Register values as last written; the near-target runs aim at the targets.
  logic signed [REG_W-1:0] cfg_val [NUM_REGS];

  dual_pid_tank_drive_controller uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .right_front_pos_i (right_front_pos_i),
    .left_front_pos_i  (left_front_pos_i),
    .left_back_pos_i   (left_back_pos_i),
    .right_back_pos_i  (right_back_pos_i),
    .zero_positions_i  (zero_positions_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .right_power_o     (right_power_o),
    .left_power_o      (left_power_o),
    .lateral_error_o   (lateral_error_o),
    .turn_error_o      (turn_error_o),
    .clear_encoders_o  (clear_encoders_o)
  );

  dpid_drive_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .pready_i          (pready),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .right_front_pos_i (right_front_pos_i),
    .left_front_pos_i  (left_front_pos_i),
    .left_back_pos_i   (left_back_pos_i),
    .right_back_pos_i  (right_back_pos_i),
    .zero_positions_i  (zero_positions_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .right_power_i     (right_power_o),
    .left_power_i      (left_power_o),
    .lateral_error_i   (lateral_error_o),
    .turn_error_i      (turn_error_o),
    .clear_encoders_i  (clear_encoders_o),
    .mismatch_count_o  (mismatch_count),
    .outstanding_o     (outstanding)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // The result side decides each cycle whether to take a word. A stall
  // percentage of zero keeps ready high for whole phases.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Any accepted word or register access counts as progress. A long quiet
  // stretch means the block has hung, so the run is ended as a failure.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("dual_pid_tank_drive_controller verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic longint rand_signed(input int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic signed [POS_W-1:0] fit_pos(input longint v);
    if (v > longint'(POS_MAX)) return POS_MAX;
    if (v < longint'(POS_MIN)) return POS_MIN;
    return POS_W'(v);
  endfunction

  // Full-scale values, zero, minus one and single set or cleared bits.
  function automatic logic signed [POS_W-1:0] pick_corner();
    int bit_sel;
    bit_sel = $urandom_range(0, POS_W - 1);
    case ($urandom_range(0, 5))
      0: return POS_MAX;
      1: return POS_MIN;
      2: return '0;
      3: return '1;
      4: return POS_W'(1) << bit_sel;
      default: return ~(POS_W'(1) << bit_sel);
    endcase
  endfunction

  // Writes every register from cfg_val. Each write has a setup phase, an
  // access phase and an idle gap so that psel never drops and rises in
  // the same step.
  task automatic load_config();
    for (int r = 0; r < NUM_REGS; r++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {CFG_IW'(r), 2'b00};
      pwdata  <= APB_DW'(cfg_val[r]);
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Presents one tick and holds it until the block takes it. After the
  // handshake the sender may go idle for a geometric number of cycles;
  // otherwise valid simply stays high for the next word.
  task automatic send_tick(input logic signed [POS_W-1:0] rf,
                           input logic signed [POS_W-1:0] lf,
                           input logic signed [POS_W-1:0] lb,
                           input logic signed [POS_W-1:0] rb,
                           input logic zp);
    right_front_pos_i <= rf;
    left_front_pos_i  <= lf;
    left_back_pos_i   <= lb;
    right_back_pos_i  <= rb;
    zero_positions_i  <= zp;
    in_valid_i        <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  // Lets every outstanding result drain, then lets the pipeline settle so the
  // block is fully idle before registers change.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Random ticks in runs of one kind. Push runs are long so that errors of
  // one sign pile up and drive the integrals into saturation; near-target
  // runs keep the errors small so the powers land inside the limits.
  task automatic run_random(input int total);
    int                      remaining;
    int                      run_len;
    int                      spread;
    logic                    turn_flip;
    tick_mix_e               mix;
    longint                  lat_c;
    longint                  turn_c;
    logic signed [POS_W-1:0] rf, lf, lb, rb;
    logic                    zp;
    remaining = total;
    while (remaining > 0) begin
      mix = tick_mix_e'($urandom_range(MIX_NEAR_TARGET, MIX_CORNER));
      if (mix == MIX_PUSH_HIGH || mix == MIX_PUSH_LOW) begin
        run_len = $urandom_range(60, 250);
      end else begin
        run_len = $urandom_range(8, 60);
      end
      if (run_len > remaining) run_len = remaining;
      spread    = $urandom_range(0, 3000);
      turn_flip = $urandom_range(0, 1);
      lat_c     = cfg_val[REG_LAT_TGT];
      turn_c    = cfg_val[REG_TURN_TGT] / 2;
      repeat (run_len) begin
        case (mix)
          MIX_NEAR_TARGET: begin
            rf = fit_pos(lat_c + turn_c + rand_signed(spread));
            lf = fit_pos(lat_c - turn_c + rand_signed(spread));
            lb = fit_pos(lat_c + rand_signed(spread));
            rb = fit_pos(lat_c + rand_signed(spread));
          end
          MIX_PUSH_HIGH, MIX_PUSH_LOW: begin
            rf = POS_W'($urandom_range(PUSH_LO, POS_MAX_I));
            lf = POS_W'($urandom_range(PUSH_LO, POS_MAX_I));
            lb = POS_W'($urandom_range(PUSH_LO, POS_MAX_I));
            rb = POS_W'($urandom_range(PUSH_LO, POS_MAX_I));
            // Flipping the left front wheel opens a large turn error too.
            if (turn_flip) lf = ~lf;
            if (mix == MIX_PUSH_LOW) begin
              rf = ~rf;
              lf = ~lf;
              lb = ~lb;
              rb = ~rb;
            end
          end
          MIX_CORNER: begin
            rf = pick_corner();
            lf = pick_corner();
            lb = pick_corner();
            rb = pick_corner();
          end
          default: begin
            rf = POS_W'($urandom);
            lf = POS_W'($urandom);
            lb = POS_W'($urandom);
            rb = POS_W'($urandom);
          end
        endcase
        zp = ($urandom_range(0, 99) < 8);
        send_tick(rf, lf, lb, rb, zp);
      end
      remaining -= run_len;
    end
  endtask

  initial begin : stimulus
    int         phase_items;
    gain_plan_e plan;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks with plain gains: unity P, fractional I and D, and a
    // negative turn D. Targets are small so moderate positions stay unsaturated.
    cfg_val[REG_LAT_P]    = 24'sd65536;
    cfg_val[REG_LAT_I]    = 24'sd16384;
    cfg_val[REG_LAT_D]    = 24'sd32768;
    cfg_val[REG_TURN_P]   = 24'sd65536;
    cfg_val[REG_TURN_I]   = 24'sd4096;
    cfg_val[REG_TURN_D]   = -24'sd32768;
    cfg_val[REG_LAT_TGT]  = 24'sd100;
    cfg_val[REG_TURN_TGT] = -24'sd50;
    load_config();

    send_tick('0, '0, '0, '0, 1'b0);
    send_tick(POS_MAX, POS_MAX, POS_MAX, POS_MAX, 1'b0);
    send_tick(POS_MIN, POS_MIN, POS_MIN, POS_MIN, 1'b0);
    // Widest front difference both ways; the average of each is near zero.
    send_tick(POS_MAX, POS_MIN, POS_MIN, POS_MAX, 1'b0);
    send_tick(POS_MIN, POS_MAX, POS_MAX, POS_MIN, 1'b0);
    // The average rounds toward zero on both sides.
    send_tick(-24'sd1, -24'sd1, -24'sd1, -24'sd2, 1'b0);
    send_tick(24'sd1, 24'sd1, 24'sd1, 24'sd2, 1'b0);
    // Zeroed ticks with full-scale positions still step the integrals.
    send_tick(POS_MAX, POS_MIN, POS_MAX, POS_MIN, 1'b1);
    send_tick(24'sh555555, 24'shAAAAAA, 24'sh555555, 24'shAAAAAA, 1'b0);
    send_tick(24'shAAAAAA, 24'sh555555, 24'shAAAAAA, 24'sh555555, 1'b1);
    // Small errors give powers well inside the limits.
    send_tick(24'sd200, 24'sd100, 24'sd150, 24'sd150, 1'b0);
    send_tick(-24'sd300, -24'sd100, -24'sd200, -24'sd200, 1'b0);
    send_tick(24'sd120, 24'sd90, 24'sd100, 24'sd95, 1'b0);
    send_tick('0, '0, '0, '0, 1'b1);
    drain_results();

    // Random phases, each with its own handshake pressure and register plan.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  phase_items = 450; plan = PLAN_MODERATE; end
        1: begin idle_pct = 83; stall_pct = 0;  phase_items = 300; plan = PLAN_ALL_MAX;  end
        2: begin idle_pct = 0;  stall_pct = 83; phase_items = 300; plan = PLAN_ALL_MIN;  end
        3: begin idle_pct = 12; stall_pct = 12; phase_items = 300; plan = PLAN_MODERATE; end
        default: begin
          idle_pct = 0; stall_pct = 0; phase_items = 300; plan = PLAN_CROSSED;
        end
      endcase
      case (plan)
        PLAN_ALL_MAX: begin
          foreach (cfg_val[r]) cfg_val[r] = REG_MAX;
        end
        PLAN_ALL_MIN: begin
          foreach (cfg_val[r]) cfg_val[r] = REG_MIN;
        end
        PLAN_CROSSED: begin
          // Opposite extreme targets with tiny integral gains.
          cfg_val[REG_LAT_P]    = REG_W'(rand_signed(1 << 16));
          cfg_val[REG_LAT_I]    = REG_W'(rand_signed(16));
          cfg_val[REG_LAT_D]    = REG_W'(rand_signed(1 << 16));
          cfg_val[REG_TURN_P]   = REG_W'(rand_signed(1 << 16));
          cfg_val[REG_TURN_I]   = REG_W'(rand_signed(16));
          cfg_val[REG_TURN_D]   = REG_W'(rand_signed(1 << 16));
          cfg_val[REG_LAT_TGT]  = REG_MIN;
          cfg_val[REG_TURN_TGT] = REG_MAX;
        end
        default: begin
          cfg_val[REG_LAT_P]    = REG_W'(rand_signed(1 << 17));
          cfg_val[REG_LAT_I]    = REG_W'(rand_signed(1 << 12));
          cfg_val[REG_LAT_D]    = REG_W'(rand_signed(1 << 17));
          cfg_val[REG_TURN_P]   = REG_W'(rand_signed(1 << 17));
          cfg_val[REG_TURN_I]   = REG_W'(rand_signed(1 << 12));
          cfg_val[REG_TURN_D]   = REG_W'(rand_signed(1 << 17));
          cfg_val[REG_LAT_TGT]  = REG_W'(rand_signed(1 << 17));
          cfg_val[REG_TURN_TGT] = REG_W'(rand_signed(1 << 17));
        end
      endcase
      load_config();
      run_random(phase_items);
      drain_results();
    end

    if (mismatch_count == 0) begin
      $display("dual_pid_tank_drive_controller verification clean");
    end else begin
      $display("dual_pid_tank_drive_controller verification failed");
    end
    $finish;
  end

endmodule
